// ===== rtl/rxff_pkg.sv =====
// ----------------------------------------------------------------------------
// rxff_pkg
// Shared types and constants of the receive fifo with xon/xoff flow control.
// ----------------------------------------------------------------------------
`default_nettype none

package rxff_pkg;

    localparam int unsigned THR_W = 7;

    localparam logic [THR_W-1:0] XOFF_THR_RESET = 7'd48;
    localparam logic [THR_W-1:0] XON_THR_RESET  = 7'd20;

    // register map, index of each register
    localparam logic REG_XOFF_THR = 1'b0;
    localparam logic REG_XON_THR  = 1'b1;

    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_POP  = 1'b1;

    localparam logic [1:0] FLOW_NONE = 2'd0;
    localparam logic [1:0] FLOW_XOFF = 2'd1;
    localparam logic [1:0] FLOW_XON  = 2'd2;

    typedef struct packed {
        logic       action;
        logic [7:0] data_byte;
    } t_in_beat;

    typedef struct packed {
        logic [7:0]       pop_data;
        logic             pop_valid;
        logic [1:0]       flow_send;
        logic             overflow;
        logic [THR_W-1:0] fill_level;
    } t_out_beat;

endpackage

`default_nettype wire

// ===== rtl/rx_fifo_xon_xoff_flow_control.sv =====
// ----------------------------------------------------------------------------
// rx_fifo_xon_xoff_flow_control
// Receive byte ring fifo that requests xoff/xon from the far end by fill level.
// ----------------------------------------------------------------------------
// Each input beat is a push of one byte or a pop of the oldest byte, and
// gives exactly one result beat in the cycle after it is taken. One beat can be
// taken every cycle: the byte store is a single memory with one write port
// and one registered read port, and a pop issues its read in the same cycle
// the beat is taken, so the popped byte is ready with the result. The input
// stalls only while a result is held by a stalled output. A push into a full
// fifo is dropped and flagged overflow; a pop from an empty fifo returns
// pop_valid low. XOFF is requested when the fill level rises above
// xoff_threshold while flow is on, XON when it falls below xon_threshold
// while flow is off. Thresholds sit at byte addresses 0 and 4 and should be
// written only while no beat is in flight.
`default_nettype none

module rx_fifo_xon_xoff_flow_control
    import rxff_pkg::*;
#(
    parameter int unsigned FIFO_DEPTH = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire t_in_beat    i_in,

    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output t_out_beat        o_out,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int unsigned AW   = $clog2(FIFO_DEPTH);
    localparam int unsigned CW   = $clog2(FIFO_DEPTH + 1);
    localparam int unsigned CMPW = (CW > THR_W) ? CW : THR_W;

    localparam logic [AW-1:0]   LAST_IDX = AW'(FIFO_DEPTH - 1);
    localparam logic [CMPW-1:0] FULL_OCC = CMPW'(FIFO_DEPTH);

    // configuration
    logic [THR_W-1:0] r_xoff_thr;
    logic [THR_W-1:0] r_xon_thr;
    logic             w_cfg_we;

    assign pready   = 1'b1;
    assign w_cfg_we = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xoff_thr <= XOFF_THR_RESET;
            r_xon_thr  <= XON_THR_RESET;
        end else if (w_cfg_we) begin
            case (paddr[2])
                REG_XOFF_THR: r_xoff_thr <= pwdata[THR_W-1:0];
                REG_XON_THR:  r_xon_thr  <= pwdata[THR_W-1:0];
                default:      r_xoff_thr <= r_xoff_thr;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (paddr[2])
            REG_XOFF_THR: prdata[THR_W-1:0] = r_xoff_thr;
            REG_XON_THR:  prdata[THR_W-1:0] = r_xon_thr;
            default:      prdata = '0;
        endcase
    end

    // fifo control state
    logic [AW-1:0] r_wr_idx, n_wr_idx;
    logic [AW-1:0] r_rd_idx, n_rd_idx;
    logic [CW-1:0] r_occ, n_occ;
    logic          r_flow_en, n_flow_en;
    logic          r_out_valid, n_out_valid;
    t_out_beat     r_res, n_res;

    logic [7:0]    r_mem [FIFO_DEPTH];
    logic [7:0]    r_rd_data;

    logic            w_acc;
    logic            w_we;
    logic            w_re;
    logic [CMPW-1:0] w_occ_ext;
    logic [CMPW-1:0] w_occ_inc;
    logic [CMPW-1:0] w_occ_dec;

    assign o_in_stall = r_out_valid & i_out_stall;
    assign w_acc      = i_in_valid & ~o_in_stall;
    assign w_occ_ext  = CMPW'(r_occ);
    assign w_occ_inc  = w_occ_ext + CMPW'(1);
    assign w_occ_dec  = w_occ_ext - CMPW'(1);

    always_comb begin
        n_wr_idx  = r_wr_idx;
        n_rd_idx  = r_rd_idx;
        n_occ     = r_occ;
        n_flow_en = r_flow_en;
        w_we      = 1'b0;
        w_re      = 1'b0;
        n_res     = r_res;
        if (w_acc) begin
            n_res            = '0;
            n_res.fill_level = w_occ_ext[THR_W-1:0];
            if (i_in.action == ACT_PUSH) begin
                if (w_occ_ext == FULL_OCC) begin
                    n_res.overflow = 1'b1;
                end else begin
                    w_we             = 1'b1;
                    n_wr_idx         = (r_wr_idx == LAST_IDX) ? '0 : r_wr_idx + AW'(1);
                    n_occ            = w_occ_inc[CW-1:0];
                    n_res.fill_level = w_occ_inc[THR_W-1:0];
                    if (r_flow_en && (w_occ_inc > CMPW'(r_xoff_thr))) begin
                        n_flow_en       = 1'b0;
                        n_res.flow_send = FLOW_XOFF;
                    end
                end
            end else if (r_occ != '0) begin
                // byte arrives from the memory read port next cycle
                w_re             = 1'b1;
                n_res.pop_valid  = 1'b1;
                n_rd_idx         = (r_rd_idx == LAST_IDX) ? '0 : r_rd_idx + AW'(1);
                n_occ            = w_occ_dec[CW-1:0];
                n_res.fill_level = w_occ_dec[THR_W-1:0];
                if (!r_flow_en && (w_occ_dec < CMPW'(r_xon_thr))) begin
                    n_flow_en       = 1'b1;
                    n_res.flow_send = FLOW_XON;
                end
            end
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_acc) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_idx    <= '0;
            r_rd_idx    <= '0;
            r_occ       <= '0;
            r_flow_en   <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_wr_idx    <= n_wr_idx;
            r_rd_idx    <= n_rd_idx;
            r_occ       <= n_occ;
            r_flow_en   <= n_flow_en;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    // byte store, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_wr_idx] <= i_in.data_byte;
        end
        if (w_re) begin
            r_rd_data <= r_mem[r_rd_idx];
        end
    end

    assign o_out_valid = r_out_valid;

    always_comb begin
        o_out          = r_res;
        o_out.pop_data = r_res.pop_valid ? r_rd_data : 8'd0;
    end

    // assertions
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMPW'(r_occ) <= FULL_OCC)
        else $error("fill level beyond fifo depth");

    a_empty_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_occ == '0) |-> (r_wr_idx == r_rd_idx))
        else $error("empty fifo with read and write index apart");

    a_ovf_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.overflow) |-> (!o_out.pop_valid && o_out.flow_send == FLOW_NONE))
        else $error("dropped push reported a pop or flow request");

    a_xoff_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.flow_send == FLOW_XOFF) |-> !r_flow_en)
        else $error("xoff sent while flow still on");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> $stable(r_occ) && $stable(r_flow_en))
        else $error("fifo state moved while result was stalled");

endmodule

`default_nettype wire
